/* rtl/core/llcb_pkg.sv */
// shared types, constants and helpers for the linked cell list builder
package llcb_pkg;

   localparam int MAX_CELLS   = 4096;
   localparam int CELL_AW     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CIDX_W      = 12;
   localparam int PID_W       = 16;
   localparam int POS_W       = 32;
   localparam int INV_W       = 32;
   localparam int CNT_W       = 5;
   localparam int AXIS_W      = 4;
   localparam int LIN_W       = 13;
   localparam int PROD_W      = POS_W + INV_W;
   localparam int EPOCH_W     = 8;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int REQ_DW      = 128;
   localparam int REQ_UW      = 2;
   localparam int RSP_DW      = 32;
   localparam int RSP_UW      = 2;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_READ   = 2'd2
   } llcb_cmd_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_CELLS_X = 3'd0,
      CSR_CELLS_Y = 3'd1,
      CSR_CELLS_Z = 3'd2,
      CSR_INV_X   = 3'd3,
      CSR_INV_Y   = 3'd4,
      CSR_INV_Z   = 3'd5
   } llcb_csr_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MUL,
      ST_AXIS,
      ST_LIN,
      ST_READ,
      ST_DONE,
      ST_CLEAR
   } llcb_state_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [PID_W-1:0]   head;
   } llcb_entry_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [CELL_AW-1:0] addr;
      llcb_entry_type     wdata;
   } llcb_ram_req_type;

   typedef struct packed {
      logic              clamped;
      logic              link_valid;
      logic [PID_W-1:0]  link_particle;
      logic [CIDX_W-1:0] cell_index;
   } llcb_rsp_type;

   // zero counts as one, anything above sixteen saturates
   function automatic logic [CNT_W-1:0] eff_cells(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      if (c == '0) begin
         r = CNT_W'(1);
      end else if (c > CNT_W'(16)) begin
         r = CNT_W'(16);
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

/* rtl/core/llcb_axis.sv */
// per-axis cell index: fixed-point scale, half-grid offset and clamp, two stages
module llcb_axis (
   input  logic                              clock,
   input  logic signed [llcb_pkg::POS_W-1:0] pos,
   input  logic [llcb_pkg::INV_W-1:0]        inv,
   input  logic [llcb_pkg::CNT_W-1:0]        cells,
   output logic [llcb_pkg::AXIS_W-1:0]       idx,
   output logic                              clamp
);
   import llcb_pkg::*;

   localparam int Q_W = POS_W + 2;

   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [CNT_W-1:0]         cells_ff;
   logic signed [PROD_W-1:0] sum;
   logic [POS_W-1:0]         q;
   logic [Q_W-1:0]           qb;
   logic [Q_W-1:0]           hi;
   logic [AXIS_W-1:0]        idx_in;
   logic                     clamp_in;
   logic [AXIS_W-1:0]        idx_ff;
   logic                     clamp_ff;

   assign prod_full = pos * $signed({1'b0, inv});
   assign prod_in   = prod_full[PROD_W-1:0];

   always_comb begin
      // odd cell counts add half a cell before the floor
      sum = prod_ff + (cells_ff[0] ? $signed(PROD_W'(64'h8000_0000)) : $signed(PROD_W'(0)));
      q   = sum[PROD_W-1:POS_W];
      qb  = {{2{q[POS_W-1]}}, q} + Q_W'(cells_ff[CNT_W-1:1]);
      hi  = Q_W'(cells_ff) - Q_W'(1);
      if (qb[Q_W-1]) begin
         idx_in   = '0;
         clamp_in = 1'b1;
      end else if (qb > hi) begin
         idx_in   = hi[AXIS_W-1:0];
         clamp_in = 1'b1;
      end else begin
         idx_in   = qb[AXIS_W-1:0];
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      cells_ff <= cells;
      idx_ff   <= idx_in;
      clamp_ff <= clamp_in;
   end

   assign idx   = idx_ff;
   assign clamp = clamp_ff;

endmodule

/* rtl/core/llcb_head_ram.sv */
// cell head memory: epoch tag and head particle per cell, registered read
module llcb_head_ram (
   input  logic                       clock,
   input  llcb_pkg::llcb_ram_req_type req,
   output llcb_pkg::llcb_entry_type   rd_data
);
   import llcb_pkg::*;

   llcb_entry_type mem_ff [MAX_CELLS];
   llcb_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.addr] <= req.wdata;
      end
      if (req.re) begin
         rd_data_ff <= mem_ff[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/linked_cell_list_builder_core.sv */
// Bins particles into a grid of up to 16x16x16 cells and keeps one linked chain per cell.
// An insert beat is taken when the block is free and its result is registered with the
// write back once the output is free, after the two multiply and clamp stages and the index
// and head read; no beat is taken until the one before it is done, and a head read or a clear
// holds the block the same way. The next beat is taken while a finished result still waits
// on the output. Clears bump an 8-bit epoch tag kept beside each head, so a cell is occupied
// only if its tag matches; after reset and after every 255th clear a sweep pass rewrites all
// tags, during which no beat is taken (register writes are still taken).
module linked_cell_list_builder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // particle_id, pos_x, pos_y, pos_z, cell_query, zero fill
   input  logic [llcb_pkg::REQ_DW-1:0] req_tdata,
   // command
   input  logic [llcb_pkg::REQ_UW-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // cell_index, link_particle, zero fill
   output logic [llcb_pkg::RSP_DW-1:0] rsp_tdata,
   // link_valid, clamped
   output logic [llcb_pkg::RSP_UW-1:0] rsp_tuser,
   input  logic                        csr_we,
   input  logic [llcb_pkg::CSR_AW-1:0] csr_addr,
   input  logic [llcb_pkg::CSR_DW-1:0] csr_wdata
);
   import llcb_pkg::*;

   llcb_state_type state_ff, state_in;

   logic [CNT_W-1:0]  cells_x_ff, cells_y_ff, cells_z_ff;
   logic [INV_W-1:0]  inv_x_ff, inv_y_ff, inv_z_ff;

   logic [1:0]        cmd_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic [CIDX_W-1:0] query_ff;

   logic [CELL_AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CIDX_W-1:0]  cell_ff, cell_in;
   logic               clamp_ff, clamp_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   llcb_rsp_type       rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  nx, ny, nz;
   logic [AXIS_W-1:0] idx_x, idx_y, idx_z;
   logic              clamp_x, clamp_y, clamp_z;
   logic [LIN_W-1:0]  lin_raw, lin_sat;
   logic              lin_over;
   logic              out_free;
   logic              req_beat;
   logic              link_valid;

   llcb_ram_req_type  ram_req;
   llcb_entry_type    rd_entry;

   assign nx = eff_cells(cells_x_ff);
   assign ny = eff_cells(cells_y_ff);
   assign nz = eff_cells(cells_z_ff);

   llcb_axis u_axis_x (
      .clock (clock),
      .pos   ($signed(pos_x_ff)),
      .inv   (inv_x_ff),
      .cells (nx),
      .idx   (idx_x),
      .clamp (clamp_x)
   );

   llcb_axis u_axis_y (
      .clock (clock),
      .pos   ($signed(pos_y_ff)),
      .inv   (inv_y_ff),
      .cells (ny),
      .idx   (idx_y),
      .clamp (clamp_y)
   );

   llcb_axis u_axis_z (
      .clock (clock),
      .pos   ($signed(pos_z_ff)),
      .inv   (inv_z_ff),
      .cells (nz),
      .idx   (idx_z),
      .clamp (clamp_z)
   );

   llcb_head_ram u_head_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_entry)
   );

   always_comb begin
      lin_raw = LIN_W'(idx_x) + LIN_W'(idx_y) * LIN_W'(nx)
              + LIN_W'(idx_z) * LIN_W'(nx) * LIN_W'(ny);
      lin_over = (lin_raw >= LIN_W'(MAX_CELLS));
      lin_sat  = lin_over ? LIN_W'(MAX_CELLS - 1) : lin_raw;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign link_valid = hit_ff && (rd_entry.tag == epoch_ff);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CNT_W'(1);
         cells_y_ff <= CNT_W'(1);
         cells_z_ff <= CNT_W'(1);
         inv_x_ff   <= INV_W'(32'h0001_0000);
         inv_y_ff   <= INV_W'(32'h0001_0000);
         inv_z_ff   <= INV_W'(32'h0001_0000);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CELLS_X: cells_x_ff <= csr_wdata[CNT_W-1:0];
            CSR_CELLS_Y: cells_y_ff <= csr_wdata[CNT_W-1:0];
            CSR_CELLS_Z: cells_z_ff <= csr_wdata[CNT_W-1:0];
            CSR_INV_X:   inv_x_ff   <= csr_wdata[INV_W-1:0];
            CSR_INV_Y:   inv_y_ff   <= csr_wdata[INV_W-1:0];
            CSR_INV_Z:   inv_z_ff   <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff   <= req_tuser[1:0];
         pid_ff   <= req_tdata[15:0];
         pos_x_ff <= req_tdata[47:16];
         pos_y_ff <= req_tdata[79:48];
         pos_z_ff <= req_tdata[111:80];
         query_ff <= req_tdata[123:112];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      clamp_ff    <= clamp_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      epoch_in     = epoch_ff;
      cell_in      = cell_ff;
      clamp_in     = clamp_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_req      = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = sweep_cnt_ff;
            ram_req.wdata = '0;
            if (sweep_cnt_ff == CELL_AW'(MAX_CELLS - 1)) begin
               state_in = ST_IDLE;
               epoch_in = EPOCH_FIRST;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + CELL_AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser[1:0])
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  CMD_INSERT: state_in = ST_MUL;
                  CMD_READ:   state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            state_in = ST_LIN;
         end
         ST_LIN: begin
            ram_req.re   = 1'b1;
            ram_req.addr = lin_sat[CELL_AW-1:0];
            cell_in      = CIDX_W'(lin_sat);
            clamp_in     = clamp_x || clamp_y || clamp_z || lin_over;
            hit_in       = 1'b1;
            state_in     = ST_DONE;
         end
         ST_READ: begin
            ram_req.re   = 1'b1;
            ram_req.addr = query_ff[CELL_AW-1:0];
            cell_in      = query_ff;
            clamp_in     = 1'b0;
            hit_in       = ({1'b0, query_ff} < (CIDX_W + 1)'(MAX_CELLS));
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.cell_index    = cell_ff;
               rsp_data_in.link_valid    = link_valid;
               rsp_data_in.link_particle = link_valid ? rd_entry.head : '0;
               rsp_data_in.clamped       = clamp_ff;
               if (cmd_ff == CMD_INSERT) begin
                  ram_req.we         = 1'b1;
                  ram_req.addr       = cell_ff[CELL_AW-1:0];
                  ram_req.wdata.tag  = epoch_ff;
                  ram_req.wdata.head = pid_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (epoch_ff == EPOCH_LAST) begin
                  sweep_cnt_in = '0;
                  state_in     = ST_SWEEP;
               end else begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DW - PID_W - CIDX_W)'(0),
                        rsp_data_ff.link_particle, rsp_data_ff.cell_index};
   assign rsp_tuser  = {rsp_data_ff.clamped, rsp_data_ff.link_valid};

endmodule

/* sim/tb_linked_cell_list_builder_core.sv */
// testbench for the linked cell list builder: directed and random binning traffic checked against a predictor
`timescale 1ns / 1ps

import llcb_pkg::*;

class cell_chain_tracker;
   bit [CNT_W-1:0]   cell_count[3];
   bit [INV_W-1:0]   inv_size[3];
   bit [PID_W-1:0]   head_id[MAX_CELLS];
   bit               occupied[MAX_CELLS];
   llcb_rsp_type     pending[$];
   bit [CIDX_W-1:0]  last_cell;
   int               errors;

   function new();
      cell_count = '{5'd1, 5'd1, 5'd1};
      inv_size   = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      foreach (occupied[n]) occupied[n] = 1'b0;
      last_cell = '0;
      errors    = 0;
   endfunction

   function int usable_count(bit [CNT_W-1:0] c);
      if (c == 0) return 1;
      if (c > 16) return 16;
      return int'(c);
   endfunction

   function void write_reg(llcb_csr_type a, bit [CSR_DW-1:0] v);
      case (a)
         CSR_CELLS_X: cell_count[0] = v[CNT_W-1:0];
         CSR_CELLS_Y: cell_count[1] = v[CNT_W-1:0];
         CSR_CELLS_Z: cell_count[2] = v[CNT_W-1:0];
         CSR_INV_X:   inv_size[0] = v;
         CSR_INV_Y:   inv_size[1] = v;
         CSR_INV_Z:   inv_size[2] = v;
         default: ;
      endcase
   endfunction

   // floor(pos * inv + c/2) in q32.32, then clamped into the grid
   function int axis_bin(bit [POS_W-1:0] pos, bit [INV_W-1:0] inv, int c, inout bit clamp);
      longint prod;
      longint q;
      prod = longint'($signed(pos)) * longint'({32'b0, inv});
      if (c % 2 == 1) prod += longint'(1) <<< 31;
      q = (prod >>> 32) + c / 2;
      if (q < 0) begin
         clamp = 1'b1;
         return 0;
      end
      if (q > c - 1) begin
         clamp = 1'b1;
         return c - 1;
      end
      return int'(q);
   endfunction

   function void note_beat(bit [1:0] cmd, bit [PID_W-1:0] pid, bit [POS_W-1:0] px,
                           bit [POS_W-1:0] py, bit [POS_W-1:0] pz, bit [CIDX_W-1:0] query);
      llcb_rsp_type r;
      int nx, ny, nz, lin, i, j, k;
      bit clamp;
      r = '0;
      clamp = 1'b0;
      if (cmd == CMD_CLEAR) begin
         foreach (occupied[n]) occupied[n] = 1'b0;
         pending.push_back(r);
      end else if (cmd == CMD_INSERT) begin
         nx = usable_count(cell_count[0]);
         ny = usable_count(cell_count[1]);
         nz = usable_count(cell_count[2]);
         i = axis_bin(px, inv_size[0], nx, clamp);
         j = axis_bin(py, inv_size[1], ny, clamp);
         k = axis_bin(pz, inv_size[2], nz, clamp);
         lin = i + j * nx + k * nx * ny;
         if (lin >= MAX_CELLS) begin
            lin = MAX_CELLS - 1;
            clamp = 1'b1;
         end
         r.cell_index = lin[CIDX_W-1:0];
         if (occupied[lin]) begin
            r.link_particle = head_id[lin];
            r.link_valid = 1'b1;
         end
         head_id[lin]  = pid;
         occupied[lin] = 1'b1;
         r.clamped = clamp;
         last_cell = lin[CIDX_W-1:0];
         pending.push_back(r);
      end else if (cmd == CMD_READ) begin
         r.cell_index = query;
         if (occupied[query]) begin
            r.link_particle = head_id[query];
            r.link_valid = 1'b1;
         end
         pending.push_back(r);
      end
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   function void check_beat(bit [RSP_DW-1:0] data, bit [RSP_UW-1:0] user);
      llcb_rsp_type want;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t: rsp beat with nothing expected, expected none actual %h/%h",
                  $time, data, user);
         return;
      end
      want = pending.pop_front();
      compare_field("cell_index", want.cell_index, data[11:0]);
      compare_field("link_particle", want.link_particle, data[27:12]);
      compare_field("link_valid", want.link_valid, user[0]);
      compare_field("clamped", want.clamped, user[1]);
   endfunction
endclass

module tb_linked_cell_list_builder_core;

   localparam bit [1:0] CMD_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic [REQ_UW-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [RSP_UW-1:0] rsp_tuser;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;

   bit                req_idle;
   bit                rsp_idle;
   cell_chain_tracker sb;

   linked_cell_list_builder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly positions in and up to one cell around the grid, some extremes and raw noise
   function automatic bit [POS_W-1:0] pick_coord(int axis);
      longint      half;
      int          c;
      bit [31:0]   inv;
      int unsigned mode;
      c = sb.usable_count(sb.cell_count[axis]);
      inv = sb.inv_size[axis];
      mode = $urandom_range(0, 9);
      if (mode == 0 || inv == 0) return $urandom;
      if (mode == 1) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      half = ((longint'(c) + 2) <<< 31) / longint'({32'b0, inv});
      if (half > 64'sh7fff_ffff) half = 64'sh7fff_ffff;
      return 32'(longint'($urandom_range(0, 32'(2 * half))) - half);
   endfunction

   function automatic bit [INV_W-1:0] pick_inv();
      case ($urandom_range(0, 4))
         0: return 32'h0001_0000;
         1: return 32'h0000_8000;
         2: return 32'h0002_0000;
         3: return 32'h0000_4000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(bit [1:0] cmd, bit [PID_W-1:0] pid, bit [POS_W-1:0] px,
                            bit [POS_W-1:0] py, bit [POS_W-1:0] pz, bit [CIDX_W-1:0] query);
      int gap;
      gap = req_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, query, pz, py, px, pid};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_beat(cmd, pid, px, py, pz, query);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_setup(bit [CNT_W-1:0] cx, bit [CNT_W-1:0] cy, bit [CNT_W-1:0] cz,
                             bit [INV_W-1:0] ix, bit [INV_W-1:0] iy, bit [INV_W-1:0] iz);
      llcb_csr_type    regs[6];
      bit [CSR_DW-1:0] vals[6];
      regs = '{CSR_CELLS_X, CSR_CELLS_Y, CSR_CELLS_Z, CSR_INV_X, CSR_INV_Y, CSR_INV_Z};
      vals = '{32'(cx), 32'(cy), 32'(cz), ix, iy, iz};
      for (int n = 0; n < 6; n++) begin
         csr_we    <= 1'b1;
         csr_addr  <= regs[n];
         csr_wdata <= vals[n];
         sb.write_reg(regs[n], vals[n]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_random(output bit counted);
      int unsigned     roll;
      int              span;
      bit [PID_W-1:0]  pid;
      bit [CIDX_W-1:0] query;
      roll = $urandom_range(0, 99);
      span = sb.usable_count(sb.cell_count[0]) * sb.usable_count(sb.cell_count[1])
             * sb.usable_count(sb.cell_count[2]);
      if ($urandom_range(0, 9) == 0) begin
         pid = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end else begin
         pid = 16'($urandom);
      end
      case ($urandom_range(0, 9))
         0, 1: query = 12'($urandom);
         2, 3, 4, 5: query = 12'($urandom_range(0, span - 1));
         default: query = sb.last_cell;
      endcase
      counted = (roll >= 3);
      if (roll < 3) begin
         send_beat(CMD_UNUSED, pid, $urandom, $urandom, $urandom, query);
      end else if (roll < 7) begin
         send_beat(CMD_CLEAR, pid, $urandom, $urandom, $urandom, query);
      end else if (roll < 30) begin
         send_beat(CMD_READ, pid, $urandom, $urandom, $urandom, query);
      end else begin
         send_beat(CMD_INSERT, pid, pick_coord(0), pick_coord(1), pick_coord(2), query);
      end
   endtask

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int counted_items;
      bit counted;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      sb = new();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset grid: a single unit cell
      send_beat(CMD_INSERT, 16'h0000, 32'h0, 32'h0, 32'h0, 12'($urandom));
      send_beat(CMD_INSERT, 16'hffff, 32'h0, 32'h0, 32'h0, 12'($urandom));
      send_beat(CMD_READ, 16'($urandom), $urandom, $urandom, $urandom, 12'h000);
      send_beat(CMD_READ, 16'($urandom), $urandom, $urandom, $urandom, 12'hfff);
      send_beat(CMD_INSERT, 16'h1234, 32'h7fff_ffff, 32'h0, 32'h0, 12'h000);
      send_beat(CMD_INSERT, 16'h0042, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 12'h000);
      send_beat(CMD_UNUSED, 16'($urandom), $urandom, $urandom, $urandom, 12'($urandom));
      send_beat(CMD_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, 12'($urandom));
      send_beat(CMD_READ, 16'($urandom), $urandom, $urandom, $urandom, 12'h000);
      settle_block();

      // zero and over-range cell counts
      load_setup(5'd31, 5'd0, 5'd17, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
      send_beat(CMD_INSERT, 16'h0001, 32'hfff8_0000, 32'h0, 32'h0003_8000, 12'hfff);
      send_beat(CMD_READ, 16'hffff, $urandom, $urandom, $urandom, sb.last_cell);
      send_beat(CMD_INSERT, 16'h0002, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 12'h0);
      send_beat(CMD_INSERT, 16'h0003, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 12'h0);
      send_beat(CMD_INSERT, 16'h0004, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff, 12'h0);
      send_beat(CMD_INSERT, 16'h0005, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff, 12'h0);
      send_beat(CMD_READ, 16'h0, $urandom, $urandom, $urandom, sb.last_cell);
      send_beat(CMD_READ, 16'h0, $urandom, $urandom, $urandom, 12'hfff);
      send_beat(CMD_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, 12'($urandom));
      send_beat(CMD_READ, 16'h0, $urandom, $urandom, $urandom, sb.last_cell);
      settle_block();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: load_setup(5'd16, 5'd16, 5'd16, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
            1: load_setup(5'd1, 5'd1, 5'd1, 32'h0, 32'h0, 32'h0);
            2: load_setup(5'd0, 5'd17, 5'd31, $urandom, $urandom, $urandom);
            default: load_setup(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                                5'($urandom_range(1, 16)), pick_inv(), pick_inv(), pick_inv());
         endcase
         req_idle = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         rsp_idle = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         counted_items = 0;
         while (counted_items < 47) begin
            send_random(counted);
            counted_items += counted;
         end
         settle_block();
      end

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* linked_cell_list_builder_core.f */
rtl/core/llcb_pkg.sv
rtl/core/llcb_axis.sv
rtl/core/llcb_head_ram.sv
rtl/core/linked_cell_list_builder_core.sv
sim/tb_linked_cell_list_builder_core.sv
